>>> hw/rtl/running_median_and_variance_defines.svh
// Assertion macros shared by the running median and variance RTL.
`ifndef RUNNING_MEDIAN_AND_VARIANCE_DEFINES_SVH
`define RUNNING_MEDIAN_AND_VARIANCE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define RMV_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RMV_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) cond |=> prop) else $error(msg);
`else
`define RMV_ASSERT(label, prop, msg)
`define RMV_ASSERT_NEXT(label, cond, prop, msg)
`endif
`endif

>>> hw/rtl/rmv_pkg.sv
// Package with widths, the sequencer states and the heap ordering function.
`default_nettype none
package rmv_pkg;

    localparam int CAPACITY_DEFAULT = 1024;
    localparam int SAMPLE_WIDTH     = 16;
    localparam int FRACTION_BITS    = 16;
    localparam int MED_W            = SAMPLE_WIDTH + 1;
    localparam int MEAN_W           = SAMPLE_WIDTH + FRACTION_BITS;
    localparam int DELTA_W          = MEAN_W + 2;
    localparam int MUL_W            = MEAN_W;
    localparam int MUL_HALF         = MUL_W / 2;
    localparam int PROD_W           = 2 * MUL_W;
    localparam int INC_W            = PROD_W - FRACTION_BITS + 1;
    localparam int SUM_W            = 60;
    localparam int VAR_W            = 2 * SAMPLE_WIDTH + FRACTION_BITS;
    localparam int SD_W             = 32;
    localparam int COUNT_OUT_W      = 11;
    localparam int DIV_W            = SUM_W;
    localparam int SQ_IN_W          = 64;
    localparam int SQ_STEPS         = SQ_IN_W / 2;
    localparam int STEP_W           = $clog2(DIV_W + 1);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MEAN_PREP,
        ST_MEAN_DIV,
        ST_MEAN_UPD,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_MUL_ACC,
        ST_SUM_UPD,
        ST_VAR_PREP,
        ST_VAR_DIV,
        ST_VAR_RND,
        ST_SQRT,
        ST_PP_START,
        ST_SD_RDL,
        ST_SD_RDR,
        ST_SD_CMP,
        ST_PU_START,
        ST_PU_RD,
        ST_PU_CMP,
        ST_MEDIAN,
        ST_OUT
    } state_t;

    // True when a must sit above b: max-heap order when is_max, else min-heap order.
    function automatic logic ranks_above(input logic signed [SAMPLE_WIDTH-1:0] a,
                                         input logic signed [SAMPLE_WIDTH-1:0] b,
                                         input logic is_max);
        ranks_above = is_max ? (a > b) : (a < b);
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/running_median_and_variance.sv
// Channel     | Signals                          | Direction
// ------------+----------------------------------+----------
// input       | in_valid, in_ready, sample       | in
// result      | out_valid, out_ready, fields     | out
//
// An accepted sample runs a 34-step mean division, a multiply (low half, high half, then
// accumulate), a 60-step variance division and a 32-step square root, then the heap update:
// each level sifted down passes ST_SD_RDL, ST_SD_RDR and ST_SD_CMP, each level sifted up
// passes ST_PU_RD and ST_PU_CMP. The first sample skips the variance division and the root.
// A dropped sample (capacity full) has its result in the cycle after acceptance. Reset clears
// sizes, count, mean and sum; heap memories are not cleared. A stalled result holds ST_OUT.
`default_nettype none
`include "running_median_and_variance_defines.svh"
module running_median_and_variance
    import rmv_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEFAULT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0] sample,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic signed [MED_W-1:0]             median_doubled,
    output logic signed [MEAN_W-1:0]            mean_value,
    output logic [VAR_W-1:0]                    variance_value,
    output logic [SD_W-1:0]                     std_deviation,
    output logic [COUNT_OUT_W-1:0]              sample_count,
    output logic                                dropped_flag
);

    localparam int HALF  = (CAPACITY + 1) / 2;
    localparam int AW    = (HALF > 1) ? $clog2(HALF) : 1;
    localparam int SW    = $clog2(HALF + 1);
    localparam int IW    = SW + 1;
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam logic [SUM_W:0] SUM_MAX = {1'b0, {SUM_W{1'b1}}};
    localparam logic [DIV_W:0] VAR_MAX = (DIV_W + 1)'({VAR_W{1'b1}});

    state_t state_reg, state_next;

    logic [CW-1:0]                  count_reg;
    logic [SW-1:0]                  lo_size_reg, hi_size_reg;
    logic signed [MEAN_W-1:0]       mean_reg;
    logic [SUM_W-1:0]               sum_reg;
    logic                           drop_reg;
    logic signed [SAMPLE_WIDTH-1:0] x_reg;
    logic signed [DELTA_W-1:0]      delta_reg;
    logic [DELTA_W-1:0]             mag_reg;
    logic                           dneg_reg;
    logic [MUL_W-1:0]               m2_reg;
    logic [PROD_W-1:0]              prod_reg;
    logic [MUL_W+MUL_HALF-1:0]      pp_reg;
    logic [DIV_W-1:0]               quo_reg;
    logic [CW-1:0]                  rem_reg, dvs_reg;
    logic [STEP_W-1:0]              step_reg;
    logic [VAR_W-1:0]               var_reg;
    logic [SQ_IN_W-1:0]             ysh_reg;
    logic [SD_W-1:0]                root_reg;
    logic [SD_W+1:0]                srem_reg;
    logic signed [MED_W-1:0]        med_reg;

    logic                           psel_reg;
    logic signed [SAMPLE_WIDTH-1:0] t_reg, hv_reg, lval_reg;
    logic [SW-1:0]                  hidx_reg;
    logic                           rok_reg;
    logic signed [SAMPLE_WIDTH-1:0] top_lo_reg, top_hi_reg;

    logic signed [SAMPLE_WIDTH-1:0] lo_mem [HALF];
    logic signed [SAMPLE_WIDTH-1:0] hi_mem [HALF];
    logic signed [SAMPLE_WIDTH-1:0] lo_rdata, hi_rdata;

    logic                           mem_re, mem_we;
    logic [AW-1:0]                  mem_raddr, mem_waddr;
    logic signed [SAMPLE_WIDTH-1:0] mem_wdata;

    // Heap control decisions.
    logic                           act_hi, is_max;
    logic [SW-1:0]                  act_size, push_size;
    logic signed [SAMPLE_WIDTH-1:0] rdata, best_lval;
    logic [IW-1:0]                  lidx, ridx;
    logic                           l_ok, r_ok, l_wins, r_wins, sd_move;
    logic [IW-1:0]                  sd_bidx;
    logic signed [SAMPLE_WIDTH-1:0] sd_bval;
    logic [SW-1:0]                  pidx;
    logic                           pu_up, pu_full;
    logic                           pp_hi, pp_sift;
    logic [SW-1:0]                  pp_size;
    logic signed [SAMPLE_WIDTH-1:0] pp_top;
    logic                           full;

    // Arithmetic.
    logic signed [DELTA_W-1:0]      xf, mean_ext, d_old, mean_new, d_new;
    logic [DELTA_W-1:0]             q_val;
    logic [CW-1:0]                  n_val;
    logic [CW:0]                    div_sh;
    logic                           div_ge;
    logic [MUL_HALF-1:0]            mul_op;
    logic [MUL_W+MUL_HALF-1:0]      mul_out;
    logic [INC_W-1:0]               inc;
    logic                           sum_neg;
    logic [SUM_W:0]                 sum_add;
    logic [DIV_W:0]                 var_rnd;
    logic [SD_W+3:0]                sq_sh, sq_trial;
    logic                           sq_ge;

    always_comb
    begin
        case (state_reg) inside
            ST_PU_START, ST_PU_RD, ST_PU_CMP: act_hi = !psel_reg;
            default:                          act_hi = psel_reg;
        endcase
        is_max    = !act_hi;
        act_size  = act_hi ? hi_size_reg : lo_size_reg;
        push_size = psel_reg ? lo_size_reg : hi_size_reg;
        rdata     = act_hi ? hi_rdata : lo_rdata;
        lidx      = {hidx_reg, 1'b1};
        ridx      = lidx + IW'(1);
        l_ok      = lidx < {1'b0, act_size};
        r_ok      = ridx < {1'b0, act_size};
        l_wins    = ranks_above(lval_reg, hv_reg, is_max);
        best_lval = l_wins ? lval_reg : hv_reg;
        r_wins    = rok_reg && ranks_above(rdata, best_lval, is_max);
        sd_move   = l_wins || r_wins;
        sd_bidx   = r_wins ? ridx : lidx;
        sd_bval   = r_wins ? rdata : lval_reg;
        pidx      = (hidx_reg - SW'(1)) >> 1;
        pu_up     = ranks_above(hv_reg, rdata, is_max);
        pu_full   = {1'b0, push_size} >= IW'(HALF);
        pp_hi     = lo_size_reg > hi_size_reg;
        pp_size   = pp_hi ? lo_size_reg : hi_size_reg;
        pp_top    = pp_hi ? top_lo_reg : top_hi_reg;
        pp_sift   = (pp_size != '0) && ranks_above(pp_top, x_reg, pp_hi);
        full      = count_reg >= CW'(CAPACITY);
    end

    always_comb
    begin
        xf       = DELTA_W'(signed'({x_reg, {FRACTION_BITS{1'b0}}}));
        mean_ext = DELTA_W'(mean_reg);
        d_old    = xf - mean_ext;
        n_val    = count_reg + CW'(1);
        q_val    = quo_reg[DELTA_W-1:0];
        mean_new = delta_reg[DELTA_W-1] ? mean_ext - signed'(q_val)
                                        : mean_ext + signed'(q_val);
        d_new    = xf - mean_new;
        div_sh   = {rem_reg, quo_reg[DIV_W-1]};
        div_ge   = div_sh >= {1'b0, dvs_reg};
        mul_op   = (state_reg == ST_MUL_HI) ? m2_reg[MUL_W-1:MUL_HALF]
                                            : m2_reg[MUL_HALF-1:0];
        mul_out  = mag_reg[MUL_W-1:0] * mul_op;
        inc      = INC_W'(prod_reg[PROD_W-1:FRACTION_BITS])
                   + INC_W'(prod_reg[FRACTION_BITS-1]);
        sum_neg  = (delta_reg[DELTA_W-1] != dneg_reg) && (mag_reg != '0) && (m2_reg != '0);
        sum_add  = {1'b0, sum_reg} + (SUM_W + 1)'(inc);
        var_rnd  = {1'b0, quo_reg}
                   + (DIV_W + 1)'(rem_reg >= (dvs_reg - (dvs_reg >> 1)));
        sq_sh    = {srem_reg, ysh_reg[SQ_IN_W-1 -: 2]};
        sq_trial = {2'b00, root_reg, 2'b01};
        sq_ge    = sq_sh >= sq_trial;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (in_valid) state_next = full ? ST_OUT : ST_MEAN_PREP;
            ST_MEAN_PREP: state_next = ST_MEAN_DIV;
            ST_MEAN_DIV:  if (step_reg == STEP_W'(1)) state_next = ST_MEAN_UPD;
            ST_MEAN_UPD:  state_next = ST_MUL_LO;
            ST_MUL_LO:    state_next = ST_MUL_HI;
            ST_MUL_HI:    state_next = ST_MUL_ACC;
            ST_MUL_ACC:   state_next = ST_SUM_UPD;
            ST_SUM_UPD:   state_next = ST_VAR_PREP;
            ST_VAR_PREP:  state_next = (count_reg > CW'(1)) ? ST_VAR_DIV : ST_PP_START;
            ST_VAR_DIV:   if (step_reg == STEP_W'(1)) state_next = ST_VAR_RND;
            ST_VAR_RND:   state_next = ST_SQRT;
            ST_SQRT:      if (step_reg == STEP_W'(1)) state_next = ST_PP_START;
            ST_PP_START:  state_next = pp_sift ? ST_SD_RDL : ST_PU_START;
            ST_SD_RDL:    state_next = l_ok ? ST_SD_RDR : ST_PU_START;
            ST_SD_RDR:    state_next = ST_SD_CMP;
            ST_SD_CMP:    state_next = sd_move ? ST_SD_RDL : ST_PU_START;
            ST_PU_START:  state_next = pu_full ? ST_MEDIAN : ST_PU_RD;
            ST_PU_RD:     state_next = (hidx_reg == '0) ? ST_MEDIAN : ST_PU_CMP;
            ST_PU_CMP:    state_next = pu_up ? ST_PU_RD : ST_MEDIAN;
            ST_MEDIAN:    state_next = ST_OUT;
            ST_OUT:       if (out_ready) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        mem_re    = 1'b0;
        mem_we    = 1'b0;
        mem_raddr = lidx[AW-1:0];
        mem_waddr = hidx_reg[AW-1:0];
        mem_wdata = hv_reg;
        unique case (state_reg)
            ST_IDLE: in_ready = 1'b1;
            ST_OUT:  out_valid = 1'b1;
            ST_SD_RDL:
            begin
                mem_re = l_ok;
                mem_we = !l_ok;
            end
            ST_SD_RDR:
            begin
                mem_re    = r_ok;
                mem_raddr = ridx[AW-1:0];
            end
            ST_SD_CMP:
            begin
                mem_we    = 1'b1;
                mem_wdata = sd_move ? sd_bval : hv_reg;
            end
            ST_PU_RD:
            begin
                mem_we    = (hidx_reg == '0);
                mem_re    = (hidx_reg != '0);
                mem_raddr = pidx[AW-1:0];
            end
            ST_PU_CMP:
            begin
                mem_we    = 1'b1;
                mem_wdata = pu_up ? rdata : hv_reg;
            end
            default: ;
        endcase
    end

    // Heap memories: one write and one read per cycle, registered read data.
    always_ff @(posedge clk)
    begin
        if (mem_we && !act_hi)
        begin
            lo_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_we && act_hi)
        begin
            hi_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            lo_rdata <= lo_mem[mem_raddr];
            hi_rdata <= hi_mem[mem_raddr];
        end
    end

    // The roots are mirrored in registers so the median needs no memory read.
    always_ff @(posedge clk)
    begin
        if (mem_we && (mem_waddr == '0))
        begin
            if (act_hi)
            begin
                top_hi_reg <= mem_wdata;
            end
            else
            begin
                top_lo_reg <= mem_wdata;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            lo_size_reg <= '0;
            hi_size_reg <= '0;
            mean_reg    <= '0;
            sum_reg     <= '0;
            drop_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        drop_reg <= full;
                    end
                end
                ST_MEAN_PREP: count_reg <= n_val;
                ST_MEAN_UPD:  mean_reg <= MEAN_W'(mean_new);
                ST_SUM_UPD:
                begin
                    if (sum_neg)
                    begin
                        sum_reg <= (SUM_W'(inc) > sum_reg) ? '0 : sum_reg - SUM_W'(inc);
                    end
                    else
                    begin
                        sum_reg <= (sum_add > SUM_MAX) ? SUM_MAX[SUM_W-1:0]
                                                       : sum_add[SUM_W-1:0];
                    end
                end
                ST_PU_START:
                begin
                    if (!pu_full)
                    begin
                        if (psel_reg)
                        begin
                            lo_size_reg <= lo_size_reg + SW'(1);
                        end
                        else
                        begin
                            hi_size_reg <= hi_size_reg + SW'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                x_reg <= sample;
            end
            ST_MEAN_PREP:
            begin
                delta_reg <= d_old;
                mag_reg   <= d_old[DELTA_W-1] ? DELTA_W'(-d_old) : DELTA_W'(d_old);
                quo_reg   <= {(d_old[DELTA_W-1] ? DELTA_W'(-d_old) : DELTA_W'(d_old))
                              + DELTA_W'(n_val >> 1), {(DIV_W - DELTA_W){1'b0}}};
                rem_reg   <= '0;
                dvs_reg   <= n_val;
                step_reg  <= STEP_W'(DELTA_W);
            end
            ST_MEAN_DIV, ST_VAR_DIV:
            begin
                rem_reg  <= div_ge ? CW'(div_sh - {1'b0, dvs_reg}) : div_sh[CW-1:0];
                quo_reg  <= {quo_reg[DIV_W-2:0], div_ge};
                step_reg <= step_reg - STEP_W'(1);
            end
            ST_MEAN_UPD:
            begin
                dneg_reg <= d_new[DELTA_W-1];
                m2_reg   <= d_new[DELTA_W-1] ? MUL_W'(-d_new) : MUL_W'(d_new);
            end
            ST_MUL_LO:  prod_reg <= PROD_W'(mul_out);
            ST_MUL_HI:  pp_reg <= mul_out;
            ST_MUL_ACC: prod_reg <= prod_reg + {pp_reg, {MUL_HALF{1'b0}}};
            ST_VAR_PREP:
            begin
                quo_reg  <= sum_reg;
                rem_reg  <= '0;
                dvs_reg  <= count_reg - CW'(1);
                step_reg <= STEP_W'(DIV_W);
                var_reg  <= '0;
                root_reg <= '0;
            end
            ST_VAR_RND:
            begin
                var_reg  <= (var_rnd > VAR_MAX) ? VAR_MAX[VAR_W-1:0] : var_rnd[VAR_W-1:0];
                ysh_reg  <= {((var_rnd > VAR_MAX) ? VAR_MAX[VAR_W-1:0] : var_rnd[VAR_W-1:0]),
                             {(SQ_IN_W - VAR_W){1'b0}}};
                root_reg <= '0;
                srem_reg <= '0;
                step_reg <= STEP_W'(SQ_STEPS);
            end
            ST_SQRT:
            begin
                srem_reg <= sq_ge ? (SD_W + 2)'(sq_sh - sq_trial) : (SD_W + 2)'(sq_sh);
                root_reg <= {root_reg[SD_W-2:0], sq_ge};
                ysh_reg  <= ysh_reg << 2;
                step_reg <= step_reg - STEP_W'(1);
            end
            ST_PP_START:
            begin
                // psel_reg set means the upper heap is sifted and the lower heap grows.
                psel_reg <= !pp_hi;
                t_reg    <= pp_sift ? pp_top : x_reg;
                hv_reg   <= x_reg;
                hidx_reg <= '0;
            end
            ST_SD_RDR:
            begin
                lval_reg <= rdata;
                rok_reg  <= r_ok;
            end
            ST_SD_CMP:
            begin
                if (sd_move)
                begin
                    hidx_reg <= SW'(sd_bidx);
                end
            end
            ST_PU_START:
            begin
                hv_reg   <= t_reg;
                hidx_reg <= push_size;
            end
            ST_PU_CMP:
            begin
                if (pu_up)
                begin
                    hidx_reg <= pidx;
                end
            end
            ST_MEDIAN:
            begin
                if (lo_size_reg > hi_size_reg)
                begin
                    med_reg <= {top_lo_reg, 1'b0};
                end
                else if (lo_size_reg != '0)
                begin
                    med_reg <= MED_W'(top_lo_reg) + MED_W'(top_hi_reg);
                end
                else
                begin
                    med_reg <= '0;
                end
            end
            default: ;
        endcase
    end

    assign median_doubled = med_reg;
    assign mean_value     = mean_reg;
    assign variance_value = var_reg;
    assign std_deviation  = root_reg;
    assign sample_count   = COUNT_OUT_W'(count_reg);
    assign dropped_flag   = drop_reg;

    `RMV_ASSERT(a_hs_exclusive, !(in_ready && out_valid), "input and result handshakes overlap")
    `RMV_ASSERT(a_heap_balance, (lo_size_reg == hi_size_reg) || (lo_size_reg == hi_size_reg + SW'(1)), "heap sizes out of balance")
    `RMV_ASSERT(a_size_count, (state_reg != ST_IDLE) || (CW'(lo_size_reg) + CW'(hi_size_reg) == count_reg), "heap sizes disagree with sample count")
    `RMV_ASSERT_NEXT(a_drop_full, (in_valid && in_ready && full), dropped_flag && out_valid, "dropped transaction not flagged")

endmodule
`default_nettype wire
